FILE: hw/rtl/smta_pkg.sv
// ----------------------------------------------------------------------------
// smta_pkg
// Shared types, codes and constants of the sprite memory table allocator.
// ----------------------------------------------------------------------------
package smta_pkg;

    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_KEY_BITS   = 32;
    localparam int IMAGE_KEY_BITS = 32;
    localparam int SIDE_BITS      = 7;
    localparam int ADDR_BITS      = 16;
    localparam int TILE_BITS      = 12;
    localparam int TILE_SHIFT     = 4;
    localparam int INDEX_BITS     = 5;
    localparam int AREA_BITS      = 2 * SIDE_BITS;

    localparam logic [SIDE_BITS-1:0] SIDE_8  = 7'd8;
    localparam logic [SIDE_BITS-1:0] SIDE_16 = 7'd16;
    localparam logic [SIDE_BITS-1:0] SIDE_32 = 7'd32;
    localparam logic [SIDE_BITS-1:0] SIDE_64 = 7'd64;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_ADDED     = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic                      opcode;
        logic [IMAGE_KEY_BITS-1:0] image_key;
        logic [SIDE_BITS-1:0]      width_pixels;
        logic [SIDE_BITS-1:0]      height_pixels;
    } t_in_beat;

    typedef struct packed {
        t_status                status;
        logic [INDEX_BITS-1:0]  entry_index;
        logic [ADDR_BITS-1:0]   start_address;
        logic [TILE_BITS-1:0]   start_tile;
        logic [ADDR_BITS-1:0]   next_free_address;
        logic                   address_overflow;
    } t_out_beat;

    typedef enum logic [1:0] {
        RD_ZERO  = 2'd0,
        RD_PLUS1 = 2'd1,
        RD_PLUS2 = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        RES_EMPTY = 2'd0,
        RES_ROW   = 2'd1,
        RES_NEW   = 2'd2
    } t_res_src;

    typedef struct packed {
        logic     load;
        logic     step;
        logic     latch_last;
        logic     append;
        logic     shift_wr;
        logic     dec_count;
        logic     set_res;
        t_res_src res_src;
        t_status  res_status;
        t_rd_sel  rd_sel;
        logic     load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic count_zero;
        logic hit;
        logic last;
        logic more;
        logic sides_ok;
        logic full;
        logic op_remove;
        logic out_free;
    } t_dp_stat;

    function automatic logic side_ok(input logic [SIDE_BITS-1:0] s);
        return (s == SIDE_8) || (s == SIDE_16) || (s == SIDE_32) || (s == SIDE_64);
    endfunction

endpackage

FILE: hw/rtl/smta_dp.sv
// ----------------------------------------------------------------------------
// smta_dp
// Datapath: entry table memory, request registers, scan index, fill count,
// allocation adder and the result and output registers.
// ----------------------------------------------------------------------------
module smta_dp import smta_pkg::*; #(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  t_ctl_cmd  i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int KW    = (KEY_BITS < IMAGE_KEY_BITS) ? KEY_BITS : IMAGE_KEY_BITS;
    localparam int DEPTH = 2 ** IW;

    typedef struct packed {
        logic [KW-1:0]        key;
        logic [ADDR_BITS-1:0] start_addr;
        logic [TILE_BITS-1:0] tile;
        logic [ADDR_BITS-1:0] end_addr;
    } t_row;

    t_row                 r_mem [DEPTH];
    t_row                 r_rd_data;
    logic                 r_op;
    logic [KW-1:0]        r_key;
    logic [SIDE_BITS-1:0] r_w;
    logic [SIDE_BITS-1:0] r_h;
    logic [AREA_BITS-1:0] r_area;
    logic [IW-1:0]        r_scan;
    logic [CW-1:0]        r_count;
    logic [ADDR_BITS-1:0] r_last_end;
    t_out_beat            r_res;
    t_out_beat            n_res;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    t_row                 wr_data;
    logic                 wr_en;
    logic [CW-1:0]        scan_p1;
    logic [ADDR_BITS-1:0] new_end;
    t_row                 new_row;

    assign scan_p1 = CW'(r_scan) + CW'(1);
    assign new_end = r_last_end + ADDR_BITS'(r_area);

    always_comb begin
        new_row.key        = r_key;
        new_row.start_addr = r_last_end;
        new_row.tile       = r_last_end[ADDR_BITS-1:TILE_SHIFT];
        new_row.end_addr   = new_end;
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ZERO:  rd_addr = '0;
            RD_PLUS1: rd_addr = r_scan + IW'(1);
            RD_PLUS2: rd_addr = r_scan + IW'(2);
            default:  rd_addr = '0;
        endcase
    end

    assign wr_en   = i_cmd.append | i_cmd.shift_wr;
    assign wr_addr = i_cmd.append ? IW'(r_count) : r_scan;
    assign wr_data = i_cmd.append ? new_row : r_rd_data;

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_res        = '0;
        n_res.status = i_cmd.res_status;
        case (i_cmd.res_src)
            RES_ROW: begin
                n_res.entry_index       = INDEX_BITS'(r_scan);
                n_res.start_address     = r_rd_data.start_addr;
                n_res.start_tile        = r_rd_data.tile;
                n_res.next_free_address = r_rd_data.end_addr;
                n_res.address_overflow  = r_rd_data.end_addr[ADDR_BITS-1];
            end
            RES_NEW: begin
                n_res.entry_index       = INDEX_BITS'(r_count);
                n_res.start_address     = r_last_end;
                n_res.start_tile        = r_last_end[ADDR_BITS-1:TILE_SHIFT];
                n_res.next_free_address = new_end;
                n_res.address_overflow  = new_end[ADDR_BITS-1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_data.opcode;
            r_key  <= i_in_data.image_key[KW-1:0];
            r_w    <= i_in_data.width_pixels;
            r_h    <= i_in_data.height_pixels;
            r_area <= AREA_BITS'(i_in_data.width_pixels) *
                      AREA_BITS'(i_in_data.height_pixels);
        end
        if (i_cmd.load) begin
            r_scan <= '0;
        end else if (i_cmd.step) begin
            r_scan <= r_scan + IW'(1);
        end
        if (i_cmd.load) begin
            r_last_end <= '0;
        end else if (i_cmd.latch_last) begin
            r_last_end <= r_rd_data.end_addr;
        end
        if (i_cmd.set_res) begin
            r_res <= n_res;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.hit        = (r_rd_data.key == r_key);
        o_stat.last       = (scan_p1 == r_count);
        o_stat.more       = (scan_p1 < r_count);
        o_stat.sides_ok   = side_ok(r_w) & side_ok(r_h);
        o_stat.full       = (r_count == CW'(ENTRIES));
        o_stat.op_remove  = (r_op == OP_REMOVE);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/smta_ctl.sv
// ----------------------------------------------------------------------------
// smta_ctl
// Controller: sequences key search, allocation, compaction and output.
// ----------------------------------------------------------------------------
module smta_ctl import smta_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd,
    output logic     o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    always_comb begin
        o_cmd   = '0;
        o_cmd.rd_sel     = RD_ZERO;
        o_cmd.res_src    = RES_EMPTY;
        o_cmd.res_status = ST_FOUND;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.count_zero ? S_DECIDE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.rd_sel = RD_PLUS1;
                if (i_stat.hit) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_src    = RES_ROW;
                    o_cmd.res_status = i_stat.op_remove ? ST_REMOVED : ST_FOUND;
                    n_state          = i_stat.op_remove ? S_SHIFT : S_OUT;
                end else if (i_stat.last) begin
                    o_cmd.latch_last = 1'b1;
                    n_state          = S_DECIDE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DECIDE: begin
                o_cmd.set_res = 1'b1;
                if (i_stat.op_remove) begin
                    o_cmd.res_status = ST_NOT_FOUND;
                end else if (!i_stat.sides_ok || i_stat.full) begin
                    o_cmd.res_status = ST_REJECTED;
                end else begin
                    o_cmd.res_src    = RES_NEW;
                    o_cmd.res_status = ST_ADDED;
                    o_cmd.append     = 1'b1;
                end
                n_state = S_OUT;
            end
            S_SHIFT: begin
                if (i_stat.more) begin
                    o_cmd.shift_wr = 1'b1;
                    o_cmd.step     = 1'b1;
                    o_cmd.rd_sel   = RD_PLUS2;
                end else begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;

endmodule

FILE: hw/rtl/sprite_memory_table_allocator_core.sv
// ----------------------------------------------------------------------------
// sprite_memory_table_allocator_core
// Sprite image table with a bump allocator for sprite memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table sits in a memory with one write
// and one read port, read one entry per cycle: an add scans for the key and
// then appends, a remove scans to the hit and then moves each later entry down
// one slot per cycle. The result sits in an output register, and the next
// request is taken while it waits to be collected. The table needs no clearing
// after reset.
module sprite_memory_table_allocator_core import smta_pkg::*; #(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    smta_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    smta_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a request is in progress");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_REJECTED ||
                        o_out_data.status == ST_NOT_FOUND)
        |-> o_out_data.entry_index == '0 && o_out_data.start_address == '0 &&
            o_out_data.start_tile == '0 && o_out_data.next_free_address == '0 &&
            !o_out_data.address_overflow)
        else $error("rejected or not found beat carries entry fields");

    a_added_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_ADDED
        |-> o_out_data.start_tile == o_out_data.start_address[ADDR_BITS-1:TILE_SHIFT])
        else $error("new entry tile does not match its start address");

endmodule

FILE: tb/sprite_memory_table_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// sprite_memory_table_allocator_core_tb
// Self-checking bench for the sprite table allocator: a local copy of the
// image table predicts every result beat, the checker compares each output
// beat field by field, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sprite_memory_table_allocator_core_tb import smta_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES       = DEF_ENTRIES;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [ADDR_BITS-1:0] ADDR_LIMIT = 16'h7FFF;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_beat  in_data    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    // local copy of the image table
    logic [IMAGE_KEY_BITS-1:0] tbl_key   [ENTRIES];
    logic [ADDR_BITS-1:0]      tbl_start [ENTRIES];
    logic [TILE_BITS-1:0]      tbl_tile  [ENTRIES];
    logic [ADDR_BITS-1:0]      tbl_end   [ENTRIES];
    int                        tbl_count = 0;

    t_out_beat pending_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        hold_req       = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;
    int        idle_cycles    = 0;

    sprite_memory_table_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic legal_side(input logic [SIDE_BITS-1:0] s);
        return s inside {SIDE_8, SIDE_16, SIDE_32, SIDE_64};
    endfunction

    function automatic t_out_beat row_result(input t_status st, input int idx);
        t_out_beat r;
        r.status            = st;
        r.entry_index       = idx[INDEX_BITS-1:0];
        r.start_address     = tbl_start[idx];
        r.start_tile        = tbl_tile[idx];
        r.next_free_address = tbl_end[idx];
        r.address_overflow  = tbl_end[idx] > ADDR_LIMIT;
        return r;
    endfunction

    function automatic t_out_beat empty_result(input t_status st);
        t_out_beat r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    // applies one request to the local table and returns its result beat
    function automatic t_out_beat table_apply(input t_in_beat b);
        int                   hit;
        logic [ADDR_BITS-1:0] base;
        t_out_beat            r;
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_key[i] == b.image_key) hit = i;
        end
        if (b.opcode == OP_ADD) begin
            if (hit >= 0) return row_result(ST_FOUND, hit);
            if (!legal_side(b.width_pixels) || !legal_side(b.height_pixels) ||
                tbl_count >= ENTRIES) return empty_result(ST_REJECTED);
            base = (tbl_count > 0) ? tbl_end[tbl_count-1] : '0;
            tbl_key[tbl_count]   = b.image_key;
            tbl_start[tbl_count] = base;
            tbl_tile[tbl_count]  = base[ADDR_BITS-1:TILE_SHIFT];
            tbl_end[tbl_count]   = base + ADDR_BITS'(b.width_pixels) * ADDR_BITS'(b.height_pixels);
            tbl_count++;
            return row_result(ST_ADDED, tbl_count - 1);
        end
        if (hit < 0) return empty_result(ST_NOT_FOUND);
        r = row_result(ST_REMOVED, hit);
        for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_key[i]   = tbl_key[i+1];
            tbl_start[i] = tbl_start[i+1];
            tbl_tile[i]  = tbl_tile[i+1];
            tbl_end[i]   = tbl_end[i+1];
        end
        tbl_count--;
        return r;
    endfunction

    function automatic t_in_beat make_beat(input t_opcode op,
                                           input logic [IMAGE_KEY_BITS-1:0] key,
                                           input logic [SIDE_BITS-1:0] w,
                                           input logic [SIDE_BITS-1:0] h);
        t_in_beat b;
        b.opcode        = op;
        b.image_key     = key;
        b.width_pixels  = w;
        b.height_pixels = h;
        return b;
    endfunction

    function automatic logic [SIDE_BITS-1:0] pick_side(input int pct64);
        if ($urandom_range(99) < pct64) return SIDE_64;
        case ($urandom_range(3))
            0: return SIDE_8;
            1: return SIDE_16;
            2: return SIDE_32;
            default: return SIDE_64;
        endcase
    endfunction

    function automatic logic [IMAGE_KEY_BITS-1:0] pick_key(input int pct_live);
        if (tbl_count > 0 && $urandom_range(99) < pct_live)
            return tbl_key[$urandom_range(tbl_count - 1)];
        return $urandom;
    endfunction

    // removes grow likelier as the table fills, so it hovers at mid depth
    function automatic t_in_beat random_request();
        t_in_beat b;
        b.opcode    = ($urandom_range(99) < 12 + 2 * tbl_count) ? OP_REMOVE : OP_ADD;
        b.image_key = pick_key(b.opcode == OP_REMOVE ? 80 : 35);
        if ($urandom_range(99) < 85) begin
            b.width_pixels  = pick_side(0);
            b.height_pixels = pick_side(0);
        end else begin
            b.width_pixels  = SIDE_BITS'($urandom_range(127));
            b.height_pixels = SIDE_BITS'($urandom_range(127));
        end
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        pending_results.push_back(table_apply(b));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_beat(make_beat(OP_ADD, 32'h0000_0000, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_ADD, 32'hFFFF_FFFF, SIDE_64, SIDE_64));
        send_beat(make_beat(OP_ADD, 32'h0000_0000, 7'd0, 7'd127));
        send_beat(make_beat(OP_ADD, 32'h0000_0001, 7'd0, SIDE_8));
        send_beat(make_beat(OP_ADD, 32'h0000_0002, 7'd127, SIDE_8));
        send_beat(make_beat(OP_ADD, 32'h0000_0003, SIDE_8, 7'd127));
        send_beat(make_beat(OP_ADD, 32'h0000_0004, SIDE_16, SIDE_32));
        send_beat(make_beat(OP_ADD, 32'h0000_0005, SIDE_32, SIDE_16));
        send_beat(make_beat(OP_REMOVE, 32'h0001_2345, 7'd127, 7'd0));
        send_beat(make_beat(OP_REMOVE, 32'hFFFF_FFFF, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_REMOVE, 32'h0000_0000, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_REMOVE, 32'h0000_0004, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_REMOVE, 32'h0000_0005, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_REMOVE, 32'h0000_0005, SIDE_8, SIDE_8));
        // eighth entry ends at 0x8000
        for (int i = 0; i < 9; i++)
            send_beat(make_beat(OP_ADD, 32'h0000_0100 + i, SIDE_64, SIDE_64));
        send_beat(make_beat(OP_ADD, 32'h0000_0107, 7'd0, 7'd0));
    endtask

    task automatic test_fill_to_capacity();
        while (tbl_count < ENTRIES)
            send_beat(make_beat(OP_ADD, $urandom, pick_side(70), pick_side(70)));
        send_beat(make_beat(OP_ADD, $urandom, SIDE_8, SIDE_8));
        send_beat(make_beat(OP_ADD, tbl_key[ENTRIES-1], SIDE_8, SIDE_8));
        send_beat(make_beat(OP_REMOVE, tbl_key[ENTRIES-1], SIDE_8, SIDE_8));
        send_beat(make_beat(OP_ADD, $urandom, SIDE_64, SIDE_64));
        send_beat(make_beat(OP_REMOVE, tbl_key[0], SIDE_8, SIDE_8));
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 300;
        repeat (12) send_beat(random_request());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n) send_beat(random_request());
    endtask

    task automatic test_pause_until_drained();
        repeat (5) send_beat(random_request());
        wait_drained();
        repeat (5) send_beat(random_request());
    endtask

    // receiver: long hold-off on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_left = hold_req;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result beat %p", o_out_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.entry_index !== want.entry_index ||
                    o_out_data.start_address !== want.start_address ||
                    o_out_data.start_tile !== want.start_tile ||
                    o_out_data.next_free_address !== want.next_free_address ||
                    o_out_data.address_overflow !== want.address_overflow) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("result beat differs: expected %p got %p", want, o_out_data);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sprite_memory_table_allocator_core: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_fill_to_capacity();
        test_output_hold_off();
        test_random_traffic(220, 21, 66);
        test_random_traffic(220, 66, 21);
        test_random_traffic(220, 0, 0);
        test_pause_until_drained();
        wait_drained();
        repeat (4 * ENTRIES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("sprite_memory_table_allocator_core: match");
        else
            $display("sprite_memory_table_allocator_core: mismatch");
        $finish;
    end

endmodule
